FILE: design/prpt_pkg.sv
// ----------------------------------------------------------------------------
// prpt_pkg: shared types and codes for the page region protection table
// Transaction payloads, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package prpt_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [47:0] address;
      logic [47:0] size;
      logic [2:0]  perms;
      logic [2:0]  max_perms;
      logic        private_copy;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] entries_used;
   } rsp_type;

   localparam logic [1:0] MODE_MAP     = 2'd0;
   localparam logic [1:0] MODE_CHECK   = 2'd1;
   localparam logic [1:0] MODE_PROTECT = 2'd2;
   localparam logic [1:0] MODE_DEALLOC = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_OVERLAP  = 3'd2;
   localparam logic [2:0] ST_UNMAPPED = 3'd3;
   localparam logic [2:0] ST_DENIED   = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRE,
      S_RD,
      S_EV,
      S_FREE,
      S_MAPWR,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_OVL,
      PH_WALK,
      PH_CNT,
      PH_APPLY
   } phase_type;

endpackage

FILE: design/page_region_protection_table.sv
// ----------------------------------------------------------------------------
// page_region_protection_table
// Region table with map, access check, protect and deallocate operations.
// ----------------------------------------------------------------------------
// Each entry visit is a memory read then an evaluate; a pass visits every
//   entry. Map: one pass and a write; deallocate: count and apply passes plus
//   a free-slot search per split piece; check/protect add a pass per region met.
// Throughput: one transaction at a time; req_ready is high only when idle.
// Reset: synchronous, clears valid bits, fill count, sequencer, response valid.
// ----------------------------------------------------------------------------
module page_region_protection_table #(
   parameter int REGIONS   = 16,
   parameter int ADDR_BITS = 48,
   parameter int PAGE_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prpt_pkg::rsp_type rsp_data
);
   import prpt_pkg::*;

   // byte width covers a 48-bit address plus a 48-bit size without wrap
   localparam int CW = ((ADDR_BITS > 48) ? ADDR_BITS : 48) + 2;
   localparam int PW = ADDR_BITS - PAGE_BITS;     // page numbers incl. end page
   localparam int IW = $clog2(REGIONS);
   localparam int UW = $clog2(REGIONS + 1);
   localparam int TW = $clog2(3 * REGIONS + 1);
   localparam logic [CW-1:0] AMAX  = (CW'(1) << ADDR_BITS) - CW'(1);
   localparam logic [CW-1:0] PMASK = (CW'(1) << PAGE_BITS) - CW'(1);
   localparam logic [IW-1:0] LAST  = IW'(REGIONS - 1);

   // end page is stored rather than page count
   typedef struct packed {
      logic [PW-1:0] base;
      logic [PW-1:0] lim;
      logic [2:0]    perms;
      logic [2:0]    maxp;
   } region_type;

   region_type mem [REGIONS];
   region_type rd_q;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   req_type   op_ff, op_in;
   logic [PW-1:0] sp_ff, sp_in, ep_ff, ep_in;
   logic [CW-1:0] cur_ff, cur_in, tgt_ff, tgt_in;
   logic [IW-1:0] idx_ff, idx_in, fidx_ff, fidx_in, j_ff, j_in;
   logic          ffound_ff, ffound_in;
   logic [TW-1:0] total_ff, total_in;
   region_type    pl_ff, pl_in, pr_ff, pr_in;
   logic          plv_ff, plv_in, prv_ff, prv_in;
   logic [2:0]    status_ff, status_in;
   logic [UW-1:0] used_ff, used_in;
   logic [REGIONS-1:0] valid_ff, valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          we;
   logic [IW-1:0] waddr;
   region_type    wdata;

   // ---------------- argument checks on the latched transaction -----------
   logic [CW-1:0] a_c, s_c, sum_c, sumr_c;
   logic          ovf_c, mis_c, pbad_c, rbad_c;
   logic [PW-1:0] sp_c, epm_c, epr_c;

   always_comb begin
      a_c    = CW'(op_ff.address);
      s_c    = CW'(op_ff.size);
      sum_c  = a_c + s_c;
      sumr_c = sum_c + PMASK;
      ovf_c  = (s_c > AMAX) || (sum_c > AMAX);
      mis_c  = ((a_c & PMASK) != '0) || ((s_c & PMASK) != '0);
      pbad_c = (op_ff.max_perms & op_ff.perms) != op_ff.perms;
      rbad_c = sum_c > (AMAX - PMASK);
      sp_c   = PW'(a_c >> PAGE_BITS);
      epm_c  = PW'(sum_c >> PAGE_BITS);
      epr_c  = PW'(sumr_c >> PAGE_BITS);
   end

   // ---------------- evaluation of the entry just read --------------------
   logic          v_e, hit_e, cover_e, perm_ok_e, lft_e, rgt_e, last_e;
   logic [CW-1:0] sb_e, eb_e;
   logic [2:0]    have_e;

   always_comb begin
      v_e       = valid_ff[idx_ff];
      last_e    = idx_ff == LAST;
      hit_e     = v_e && (rd_q.base < ep_ff) && (sp_ff < rd_q.lim);
      sb_e      = CW'(rd_q.base) << PAGE_BITS;
      eb_e      = CW'(rd_q.lim) << PAGE_BITS;
      cover_e   = v_e && (sb_e <= cur_ff) && (cur_ff < eb_e);
      have_e    = (op_ff.mode == MODE_CHECK) ? rd_q.perms : rd_q.maxp;
      perm_ok_e = ((op_ff.mode == MODE_PROTECT) && op_ff.private_copy) ||
                  ((have_e & op_ff.perms) == op_ff.perms);
      lft_e     = rd_q.base < sp_ff;
      rgt_e     = ep_ff < rd_q.lim;
   end

   // ---------------- next state --------------------------------------------
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      sp_in        = sp_ff;
      ep_in        = ep_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      idx_in       = idx_ff;
      fidx_in      = fidx_ff;
      j_in         = j_ff;
      ffound_in    = ffound_ff;
      total_in     = total_ff;
      pl_in        = pl_ff;
      pr_in        = pr_ff;
      plv_in       = plv_ff;
      prv_in       = prv_ff;
      status_in    = status_ff;
      used_in      = used_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            idx_in    = '0;
            ffound_in = 1'b0;
            sp_in     = sp_c;
            state_in  = S_RD;
            case (op_ff.mode)
               MODE_MAP: begin
                  ep_in    = epm_c;
                  phase_in = PH_OVL;
                  if ((s_c == '0) || mis_c || ovf_c || pbad_c) begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end
               end
               MODE_CHECK: begin
                  cur_in   = a_c;
                  tgt_in   = sum_c;
                  phase_in = PH_WALK;
                  if (s_c == '0) begin
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end
               end
               default: begin
                  ep_in    = epr_c;
                  cur_in   = CW'(sp_c) << PAGE_BITS;
                  tgt_in   = CW'(epr_c) << PAGE_BITS;
                  total_in = TW'(used_ff);
                  phase_in = (op_ff.mode == MODE_PROTECT) ? PH_WALK : PH_CNT;
                  if (s_c == '0) begin
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end else if (ovf_c || rbad_c) begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end
               end
            endcase
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            state_in = S_RD;
            idx_in   = idx_ff + IW'(1);
            case (phase_ff)
               PH_OVL: begin
                  if (hit_e) begin
                     status_in = ST_OVERLAP;
                     state_in  = S_DONE;
                  end else begin
                     if (!v_e && !ffound_ff) begin
                        fidx_in   = idx_ff;
                        ffound_in = 1'b1;
                     end
                     if (last_e) begin
                        if (ffound_ff || !v_e) begin
                           state_in = S_MAPWR;
                        end else begin
                           status_in = ST_FULL;
                           state_in  = S_DONE;
                        end
                     end
                  end
               end
               PH_WALK: begin
                  if (cover_e) begin
                     idx_in = '0;
                     cur_in = eb_e;
                     if (!perm_ok_e) begin
                        status_in = ST_DENIED;
                        state_in  = S_DONE;
                     end else if (eb_e >= tgt_ff) begin
                        if (op_ff.mode == MODE_CHECK) begin
                           status_in = ST_OK;
                           state_in  = S_DONE;
                        end else begin
                           phase_in = PH_CNT;
                           total_in = TW'(used_ff);
                        end
                     end
                  end else if (last_e) begin
                     status_in = ST_UNMAPPED;
                     state_in  = S_DONE;
                  end
               end
               PH_CNT: begin
                  if (hit_e) begin
                     if (op_ff.mode == MODE_PROTECT) begin
                        total_in = total_ff + TW'(lft_e) + TW'(rgt_e);
                     end else if (lft_e && rgt_e) begin
                        total_in = total_ff + TW'(1);
                     end else if (!lft_e && !rgt_e) begin
                        total_in = total_ff - TW'(1);
                     end
                  end
                  if (last_e) begin
                     idx_in = '0;
                     if (total_in > TW'(REGIONS)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        phase_in = PH_APPLY;
                     end
                  end
               end
               default: begin
                  if (hit_e) begin
                     pl_in = '{base: rd_q.base, lim: sp_ff, perms: rd_q.perms,
                               maxp: rd_q.maxp};
                     pr_in = '{base: ep_ff, lim: rd_q.lim, perms: rd_q.perms,
                               maxp: rd_q.maxp};
                     if (op_ff.mode == MODE_PROTECT) begin
                        plv_in = lft_e;
                        prv_in = rgt_e;
                     end else begin
                        plv_in = 1'b0;
                        prv_in = lft_e && rgt_e;
                        if (!lft_e && !rgt_e) begin
                           valid_in[idx_ff] = 1'b0;
                           used_in          = used_ff - UW'(1);
                        end
                     end
                     if (plv_in || prv_in) begin
                        j_in     = '0;
                        idx_in   = idx_ff;
                        state_in = S_FREE;
                     end
                  end
                  if (state_in == S_RD && last_e) begin
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end
               end
            endcase
         end
         S_FREE: begin
            j_in = j_ff + IW'(1);
            if (!valid_ff[j_ff]) begin
               valid_in[j_ff] = 1'b1;
               used_in        = used_ff + UW'(1);
               if (plv_ff) begin
                  plv_in = 1'b0;
               end else begin
                  prv_in = 1'b0;
               end
               if (!(plv_ff && prv_ff)) begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_RD;
                  if (idx_ff == LAST) begin
                     status_in = ST_OK;
                     state_in  = S_DONE;
                  end
               end
            end
         end
         S_MAPWR: begin
            valid_in[fidx_ff] = 1'b1;
            used_in           = used_ff + UW'(1);
            status_in         = ST_OK;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = '{status: status_ff, entries_used: 5'(used_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------- outputs and table write port ---------------------------
   always_comb begin
      req_ready = state_ff == S_IDLE;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
      we        = 1'b0;
      waddr     = idx_ff;
      wdata     = rd_q;
      case (state_ff)
         S_EV: begin
            if (phase_ff == PH_APPLY && hit_e) begin
               we = 1'b1;
               if (op_ff.mode == MODE_PROTECT) begin
                  wdata.base  = lft_e ? sp_ff : rd_q.base;
                  wdata.lim   = rgt_e ? ep_ff : rd_q.lim;
                  wdata.perms = op_ff.perms;
                  wdata.maxp  = op_ff.private_copy ? op_ff.perms : rd_q.maxp;
               end else if (lft_e) begin
                  wdata.lim = sp_ff;
               end else if (rgt_e) begin
                  wdata.base = ep_ff;
               end
            end
         end
         S_FREE: begin
            we    = !valid_ff[j_ff];
            waddr = j_ff;
            wdata = plv_ff ? pl_ff : pr_ff;
         end
         S_MAPWR: begin
            we    = 1'b1;
            waddr = fidx_ff;
            wdata = '{base: sp_ff, lim: ep_ff, perms: op_ff.perms,
                      maxp: op_ff.max_perms};
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   // region table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_q <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_OVL;
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      sp_ff     <= sp_in;
      ep_ff     <= ep_in;
      cur_ff    <= cur_in;
      tgt_ff    <= tgt_in;
      idx_ff    <= idx_in;
      fidx_ff   <= fidx_in;
      j_ff      <= j_in;
      ffound_ff <= ffound_in;
      total_ff  <= total_in;
      pl_ff     <= pl_in;
      pr_ff     <= pr_in;
      plv_ff    <= plv_in;
      prv_ff    <= prv_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

endmodule
